// File: hdl/clipped_colorkey_blitter_top_defines.svh
// ----------------------------------------------------------------------------
// Blitter assertion macros
// Concurrent assertion wrappers on clk_i with the active-low reset.
// ----------------------------------------------------------------------------
`ifndef CLIPPED_COLORKEY_BLITTER_TOP_DEFINES_SVH
`define CLIPPED_COLORKEY_BLITTER_TOP_DEFINES_SVH

// check a property on every rising edge out of reset
`define CCB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check that a condition implies another in the same cycle
`define CCB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: hdl/ccb_pkg.sv
// ----------------------------------------------------------------------------
// Blitter package
// Word types, register map and constants of the clipped colour-key blitter.
// ----------------------------------------------------------------------------
`default_nettype none

package ccb_pkg;

  localparam int unsigned DimW   = 11;
  localparam int unsigned CoordW = 16;
  localparam int unsigned AddrW  = 32;
  localparam int unsigned PixW   = 24;
  localparam int unsigned PaddrW = 5;

  localparam logic [DimW-1:0] MaxDim = 11'd1024;

  typedef logic signed [CoordW-1:0] coord_t;

  typedef enum logic {
    FuncStart = 1'b0,
    FuncPixel = 1'b1
  } func_e;

  typedef enum logic [2:0] {
    RegSrcWidth  = 3'd0,
    RegSrcHeight = 3'd1,
    RegDstWidth  = 3'd2,
    RegDstHeight = 3'd3,
    RegKeyColor  = 3'd4,
    RegSrcBase   = 3'd5,
    RegDstBase   = 3'd6
  } reg_idx_e;

  typedef struct packed {
    func_e              func;
    logic               use_src_rect;
    logic               use_dst_rect;
    logic signed [11:0] src_x;
    logic signed [11:0] src_y;
    logic signed [11:0] rect_width;
    logic signed [11:0] rect_height;
    logic signed [11:0] dst_x;
    logic signed [11:0] dst_y;
    logic [PixW-1:0]    src_pixel;
  } in_word_t;

  typedef struct packed {
    logic             fetch_valid;
    logic [AddrW-1:0] fetch_addr;
    logic             write_en;
    logic [AddrW-1:0] write_addr;
    logic [PixW-1:0]  pixel_out;
    logic             done_res;
    logic             rejected;
  } out_word_t;

endpackage

`default_nettype wire

// File: hdl/clipped_colorkey_blitter_top.sv
// ----------------------------------------------------------------------------
// Clipped colour-key blitter
// Clips a blit to both surfaces, walks it pixel by pixel and drops key pixels.
//
//   channel  direction  handshake                 word
//   in       sink       in_valid_i / in_stall_o   in_word_i  (in_word_t)
//   out      source     out_valid_o / out_stall_i out_word_o (out_word_t)
//   cfg      sink       psel/penable/pwrite       paddr, pwdata, prdata
//
// One word per cycle sustained while no result is stalled; a taken word passes
// through the input register and then the result register.
// Start clipping, the row multiply and all cursor updates sit in the single
// stage between those registers.
// Reset clears the control state, valid flags and config registers to zero, not the word registers.
// A stalled result holds; the input register still takes a word while it is
// empty and stalls only when full behind a stalled result.
// ----------------------------------------------------------------------------
`default_nettype none

module clipped_colorkey_blitter_top
  import ccb_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output      logic              in_stall_o,
  input  wire in_word_t          in_word_i,
  output      logic              out_valid_o,
  input  wire logic              out_stall_i,
  output      out_word_t         out_word_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [PaddrW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output      logic [31:0]       prdata,
  output      logic              pready
);

  logic [DimW-1:0]  src_width_q, src_height_q, dst_width_q, dst_height_q;
  logic [PixW-1:0]  key_color_q;
  logic [AddrW-1:0] src_base_q, dst_base_q;

  logic             in_vld_q;
  in_word_t         in_q;
  logic             out_vld_q;
  out_word_t        out_q;
  out_word_t        res;
  logic             adv;

  logic             busy_q, busy_d;
  logic [DimW-1:0]  col_q, col_d, row_q, row_d;
  logic [DimW-1:0]  clip_w_q, clip_w_d, clip_h_q, clip_h_d;
  logic [AddrW-1:0] srow_q, srow_d, drow_q, drow_d;
  logic [AddrW-1:0] scur_q, scur_d, dcur_q, dcur_d;

  logic [11:0]      src_pitch, dst_pitch;

  function automatic logic [11:0] pitch_of(logic [DimW-1:0] w);
    logic [11:0] p;
    p = {w, 1'b0} + {1'b0, w} + 12'd3;
    return {p[11:2], 2'b00};
  endfunction

  function automatic logic [DimW-1:0] clamp_dim(logic [DimW-1:0] v);
    return (v > MaxDim) ? MaxDim : v;
  endfunction

  function automatic coord_t smax(coord_t a, coord_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic coord_t smin(coord_t a, coord_t b);
    return (a < b) ? a : b;
  endfunction

  // configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q  <= '0;
      src_height_q <= '0;
      dst_width_q  <= '0;
      dst_height_q <= '0;
      key_color_q  <= '0;
      src_base_q   <= '0;
      dst_base_q   <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx_e'(paddr[4:2]))
        RegSrcWidth:  src_width_q  <= clamp_dim(pwdata[DimW-1:0]);
        RegSrcHeight: src_height_q <= clamp_dim(pwdata[DimW-1:0]);
        RegDstWidth:  dst_width_q  <= clamp_dim(pwdata[DimW-1:0]);
        RegDstHeight: dst_height_q <= clamp_dim(pwdata[DimW-1:0]);
        RegKeyColor:  key_color_q  <= pwdata[PixW-1:0];
        RegSrcBase:   src_base_q   <= pwdata;
        RegDstBase:   dst_base_q   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_e'(paddr[4:2]))
      RegSrcWidth:  prdata = {21'b0, src_width_q};
      RegSrcHeight: prdata = {21'b0, src_height_q};
      RegDstWidth:  prdata = {21'b0, dst_width_q};
      RegDstHeight: prdata = {21'b0, dst_height_q};
      RegKeyColor:  prdata = {8'b0, key_color_q};
      RegSrcBase:   prdata = src_base_q;
      RegDstBase:   prdata = dst_base_q;
      default:      prdata = '0;
    endcase
  end

  // handshake
  assign adv        = in_vld_q && !(out_vld_q && out_stall_i);
  assign in_stall_o = in_vld_q && !adv;
  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= res;
    end
  end

  // blit engine
  assign src_pitch = pitch_of(src_width_q);
  assign dst_pitch = pitch_of(dst_width_q);

  always_comb begin
    coord_t           sx, sy, w, h, dx, dy, sw, sh, dw, dh;
    coord_t           cx1, cy1, w1, h1, sx1, sy1;
    coord_t           cx2, cy2, w2, h2, dx2, dy2;
    logic             reject;
    logic [22:0]      src_off, dst_off;
    logic [DimW-1:0]  col_inc, row_inc;
    busy_d   = busy_q;
    col_d    = col_q;
    row_d    = row_q;
    clip_w_d = clip_w_q;
    clip_h_d = clip_h_q;
    srow_d   = srow_q;
    drow_d   = drow_q;
    scur_d   = scur_q;
    dcur_d   = dcur_q;
    res      = '0;

    sw = {5'b0, src_width_q};
    sh = {5'b0, src_height_q};
    dw = {5'b0, dst_width_q};
    dh = {5'b0, dst_height_q};
    sx = '0;
    sy = '0;
    w  = sw;
    h  = sh;
    dx = '0;
    dy = '0;
    if (in_q.use_src_rect) begin
      sx = {{4{in_q.src_x[11]}}, in_q.src_x};
      sy = {{4{in_q.src_y[11]}}, in_q.src_y};
      w  = {{4{in_q.rect_width[11]}}, in_q.rect_width};
      h  = {{4{in_q.rect_height[11]}}, in_q.rect_height};
    end
    if (in_q.use_dst_rect) begin
      dx = {{4{in_q.dst_x[11]}}, in_q.dst_x};
      dy = {{4{in_q.dst_y[11]}}, in_q.dst_y};
    end
    reject = in_q.use_dst_rect &&
             ((dx > dw) || (dx + w < 0) || (dy > dh) || (dy + h < 0));

    // clip to destination
    cx1 = smax('0, dx);
    cy1 = smax('0, dy);
    w1  = smin(dx + w, dw) - cx1;
    h1  = smin(dy + h, dh) - cy1;
    sx1 = sx + cx1 - dx;
    sy1 = sy + cy1 - dy;

    // clip to source
    cx2 = smax('0, sx1);
    cy2 = smax('0, sy1);
    w2  = smin(sx1 + w1, sw) - cx2;
    h2  = smin(sy1 + h1, sh) - cy2;
    dx2 = cx1 + cx2 - sx1;
    dy2 = cy1 + cy2 - sy1;

    src_off = cy2[DimW-1:0] * src_pitch;
    dst_off = dy2[DimW-1:0] * dst_pitch;

    col_inc = col_q + 11'd1;
    row_inc = row_q;

    if (adv) begin
      if (in_q.func == FuncStart) begin
        busy_d = 1'b0;
        if (reject) begin
          res.done_res = 1'b1;
          res.rejected = 1'b1;
        end else if ((w2 <= 0) || (h2 <= 0)) begin
          res.done_res = 1'b1;
        end else begin
          clip_w_d = w2[DimW-1:0];
          clip_h_d = h2[DimW-1:0];
          col_d    = '0;
          row_d    = '0;
          srow_d   = src_base_q + 32'({cx2[DimW-1:0], 1'b0} + {1'b0, cx2[DimW-1:0]})
                   + 32'(src_off);
          drow_d   = dst_base_q + 32'({dx2[DimW-1:0], 1'b0} + {1'b0, dx2[DimW-1:0]})
                   + 32'(dst_off);
          scur_d   = srow_d;
          dcur_d   = drow_d;
          busy_d   = 1'b1;
          res.fetch_valid = 1'b1;
          res.fetch_addr  = srow_d;
        end
      end else if (busy_q) begin
        res.pixel_out  = in_q.src_pixel;
        res.write_en   = (in_q.src_pixel != key_color_q);
        res.write_addr = dcur_q;
        if (col_inc >= clip_w_q) begin
          col_d   = '0;
          row_inc = row_q + 11'd1;
          row_d   = row_inc;
          srow_d  = srow_q + 32'(src_pitch);
          drow_d  = drow_q + 32'(dst_pitch);
          scur_d  = srow_d;
          dcur_d  = drow_d;
        end else begin
          col_d  = col_inc;
          scur_d = scur_q + 32'd3;
          dcur_d = dcur_q + 32'd3;
        end
        if (row_inc >= clip_h_q) begin
          busy_d       = 1'b0;
          res.done_res = 1'b1;
        end else begin
          res.fetch_valid = 1'b1;
          res.fetch_addr  = scur_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      col_q    <= '0;
      row_q    <= '0;
      clip_w_q <= '0;
      clip_h_q <= '0;
      srow_q   <= '0;
      drow_q   <= '0;
      scur_q   <= '0;
      dcur_q   <= '0;
    end else begin
      busy_q   <= busy_d;
      col_q    <= col_d;
      row_q    <= row_d;
      clip_w_q <= clip_w_d;
      clip_h_q <= clip_h_d;
      srow_q   <= srow_d;
      drow_q   <= drow_d;
      scur_q   <= scur_d;
      dcur_q   <= dcur_d;
    end
  end

`include "clipped_colorkey_blitter_top_defines.svh"

  `CCB_ASSERT_IMP(a_fetch_xor_done, out_vld_q, !(out_q.fetch_valid && out_q.done_res), "fetch and done together")
  `CCB_ASSERT_IMP(a_reject_done, out_vld_q && out_q.rejected, out_q.done_res, "reject without done")
  `CCB_ASSERT_IMP(a_col_in_clip, busy_q, col_q < clip_w_q, "column beyond clipped width")
  `CCB_ASSERT_IMP(a_row_in_clip, busy_q, row_q < clip_h_q, "row beyond clipped height")

endmodule

`default_nettype wire

// File: tb/tb_clipped_colorkey_blitter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clipped colour-key blitter testbench
// Programs a series of surface settings over the register port, sends start
// and pixel words with random idling on both sides and one long output
// hold-off, and checks every result word field by field against an in-bench
// model of rectangle clipping, address walking and key suppression.
// ----------------------------------------------------------------------------
module tb_clipped_colorkey_blitter_top;
  import ccb_pkg::*;

  typedef struct {
    bit rej;
    int w, h, sx, sy, dx, dy;
  } clip_t;

  logic              clk_i    = 1'b0;
  logic              rst_ni   = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  in_word_t          in_word  = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_word_t         out_word;
  logic              psel     = 1'b0;
  logic              penable  = 1'b0;
  logic              pwrite   = 1'b0;
  logic [PaddrW-1:0] paddr    = '0;
  logic [31:0]       pwdata   = '0;
  logic [31:0]       prdata;
  logic              pready;

  logic [10:0] src_w_r    = '0;
  logic [10:0] src_h_r    = '0;
  logic [10:0] dst_w_r    = '0;
  logic [10:0] dst_h_r    = '0;
  logic [23:0] key_r      = '0;
  logic [31:0] src_base_r = '0;
  logic [31:0] dst_base_r = '0;

  bit          walk_busy  = 1'b0;
  logic [10:0] col_s      = '0;
  logic [10:0] row_s      = '0;
  logic [10:0] clip_w_s   = '0;
  logic [10:0] clip_h_s   = '0;
  logic [31:0] src_row_s  = '0;
  logic [31:0] dst_row_s  = '0;
  logic [31:0] src_cur_s  = '0;
  logic [31:0] dst_cur_s  = '0;

  in_word_t  send_q[$];
  out_word_t blit_res_q[$];
  int taken_cnt = 0;
  int res_cnt   = 0;
  int bad_cnt   = 0;
  int idle_rate = 0;
  int in_gap    = 0;
  int out_gap   = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  clipped_colorkey_blitter_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_word_o (out_word),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [10:0] dim_clamp(logic [31:0] v);
    return (v[10:0] > MaxDim) ? MaxDim : v[10:0];
  endfunction

  function automatic logic [31:0] row_pitch(logic [10:0] w);
    return (32'(w) * 32'd3 + 32'd3) & ~32'd3;
  endfunction

  function automatic clip_t clip_rect(in_word_t s);
    clip_t c;
    int cx, cy, sw, sh, dw, dh;
    sw = int'(src_w_r);
    sh = int'(src_h_r);
    dw = int'(dst_w_r);
    dh = int'(dst_h_r);
    c.rej = 1'b0;
    c.sx = 0;
    c.sy = 0;
    c.dx = 0;
    c.dy = 0;
    c.w = sw;
    c.h = sh;
    if (s.use_src_rect) begin
      c.sx = int'($signed(s.src_x));
      c.sy = int'($signed(s.src_y));
      c.w  = int'($signed(s.rect_width));
      c.h  = int'($signed(s.rect_height));
    end
    if (s.use_dst_rect) begin
      c.dx = int'($signed(s.dst_x));
      c.dy = int'($signed(s.dst_y));
      c.rej = (c.dx > dw) || (c.dx + c.w < 0) || (c.dy > dh) || (c.dy + c.h < 0);
    end
    if (!c.rej) begin
      cx = (c.dx > 0) ? c.dx : 0;
      cy = (c.dy > 0) ? c.dy : 0;
      c.w = ((c.dx + c.w < dw) ? c.dx + c.w : dw) - cx;
      c.h = ((c.dy + c.h < dh) ? c.dy + c.h : dh) - cy;
      c.sx += cx - c.dx;
      c.dx = cx;
      c.sy += cy - c.dy;
      c.dy = cy;
      cx = (c.sx > 0) ? c.sx : 0;
      cy = (c.sy > 0) ? c.sy : 0;
      c.w = ((c.sx + c.w < sw) ? c.sx + c.w : sw) - cx;
      c.h = ((c.sy + c.h < sh) ? c.sy + c.h : sh) - cy;
      c.dx += cx - c.sx;
      c.sx = cx;
      c.dy += cy - c.sy;
      c.sy = cy;
    end
    return c;
  endfunction

  function automatic out_word_t blit_step(in_word_t s);
    out_word_t r;
    clip_t c;
    r = '0;
    if (s.func == FuncStart) begin
      c = clip_rect(s);
      walk_busy = 1'b0;
      if (c.rej) begin
        r.done_res = 1'b1;
        r.rejected = 1'b1;
      end else if (c.w <= 0 || c.h <= 0) begin
        r.done_res = 1'b1;
      end else begin
        clip_w_s  = 11'(c.w);
        clip_h_s  = 11'(c.h);
        col_s     = '0;
        row_s     = '0;
        src_row_s = src_base_r + 32'(3 * c.sx) + 32'(c.sy) * row_pitch(src_w_r);
        dst_row_s = dst_base_r + 32'(3 * c.dx) + 32'(c.dy) * row_pitch(dst_w_r);
        src_cur_s = src_row_s;
        dst_cur_s = dst_row_s;
        walk_busy = 1'b1;
        r.fetch_valid = 1'b1;
        r.fetch_addr  = src_cur_s;
      end
    end else if (walk_busy) begin
      r.pixel_out  = s.src_pixel;
      r.write_en   = (s.src_pixel != key_r);
      r.write_addr = dst_cur_s;
      col_s     = col_s + 11'd1;
      src_cur_s = src_cur_s + 32'd3;
      dst_cur_s = dst_cur_s + 32'd3;
      if (col_s >= clip_w_s) begin
        col_s     = '0;
        row_s     = row_s + 11'd1;
        src_row_s = src_row_s + row_pitch(src_w_r);
        dst_row_s = dst_row_s + row_pitch(dst_w_r);
        src_cur_s = src_row_s;
        dst_cur_s = dst_row_s;
      end
      if (row_s >= clip_h_s) begin
        walk_busy  = 1'b0;
        r.done_res = 1'b1;
      end else begin
        r.fetch_valid = 1'b1;
        r.fetch_addr  = src_cur_s;
      end
    end
    return r;
  endfunction

  function automatic string res_text(out_word_t r);
    return $sformatf("fv=%0b fa=%h we=%0b wa=%h px=%h done=%0b rej=%0b", r.fetch_valid,
                     r.fetch_addr, r.write_en, r.write_addr, r.pixel_out, r.done_res,
                     r.rejected);
  endfunction

  function automatic void note_bad(string msg);
    bad_cnt++;
    if (bad_cnt <= 10) $display("mismatch: %s", msg);
  endfunction

  function automatic in_word_t rand_word();
    in_word_t r;
    r.func         = $urandom_range(0, 1) ? FuncPixel : FuncStart;
    r.use_src_rect = 1'($urandom);
    r.use_dst_rect = 1'($urandom);
    r.src_x        = 12'($urandom);
    r.src_y        = 12'($urandom);
    r.rect_width   = 12'($urandom);
    r.rect_height  = 12'($urandom);
    r.dst_x        = 12'($urandom);
    r.dst_y        = 12'($urandom);
    r.src_pixel    = 24'($urandom);
    return r;
  endfunction

  function automatic in_word_t mk_start(bit us, bit ud, int sx, int sy, int w, int h,
                                        int dx, int dy);
    in_word_t s;
    s = rand_word();
    s.func         = FuncStart;
    s.use_src_rect = us;
    s.use_dst_rect = ud;
    s.src_x        = 12'(sx);
    s.src_y        = 12'(sy);
    s.rect_width   = 12'(w);
    s.rect_height  = 12'(h);
    s.dst_x        = 12'(dx);
    s.dst_y        = 12'(dy);
    return s;
  endfunction

  function automatic in_word_t mk_pixel(logic [23:0] px);
    in_word_t p;
    p = rand_word();
    p.func      = FuncPixel;
    p.src_pixel = px;
    return p;
  endfunction

  function automatic in_word_t pixel_word();
    return mk_pixel(($urandom_range(0, 3) == 0) ? key_r : 24'($urandom));
  endfunction

  function automatic in_word_t start_word();
    in_word_t s;
    s = rand_word();
    s.func = FuncStart;
    if ($urandom_range(0, 9) != 0) begin
      s.use_src_rect = ($urandom_range(0, 4) != 0);
      s.use_dst_rect = ($urandom_range(0, 3) != 0);
      s.src_x        = 12'(int'($urandom_range(0, int'(src_w_r) + 6)) - 4);
      s.src_y        = 12'(int'($urandom_range(0, int'(src_h_r) + 6)) - 4);
      s.rect_width   = 12'(int'($urandom_range(0, 10)) - 2);
      s.rect_height  = 12'(int'($urandom_range(0, 10)) - 2);
      s.dst_x        = 12'(int'($urandom_range(0, int'(dst_w_r) + 13)) - 10);
      s.dst_y        = 12'(int'($urandom_range(0, int'(dst_h_r) + 13)) - 10);
    end
    return s;
  endfunction

  function automatic int pick_dim();
    return ($urandom_range(0, 5) == 0) ? int'($urandom_range(1024, 2047))
                                       : int'($urandom_range(1, 16));
  endfunction

  function automatic int pick_rate();
    return ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(2, 10));
  endfunction

  // driver: advance on an accepted word, hold while stalled
  always @(posedge clk_i or negedge rst_ni) begin : drive
    bit took;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_word  <= '0;
    end else begin
      took = in_valid && !in_stall;
      if (took) begin
        blit_res_q.push_back(blit_step(in_word));
        void'(send_q.pop_front());
        taken_cnt <= taken_cnt + 1;
      end
      if (!in_valid || took) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (send_q.size() > 0 && idle_rate > 0 &&
                     $urandom_range(1, idle_rate) == 1) begin
          in_gap = $urandom_range(0, 15);
          in_valid <= 1'b0;
        end else if (send_q.size() > 0) begin
          in_valid <= 1'b1;
          in_word  <= send_q[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long output hold-off once the sender has a backlog
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && taken_cnt >= 150 && send_q.size() >= 8) begin
      hold_left <= 400;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_word_t want;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (blit_res_q.size() == 0) begin
          note_bad($sformatf("unexpected word %s", res_text(out_word)));
        end else begin
          want = blit_res_q.pop_front();
          if (out_word.fetch_valid !== want.fetch_valid ||
              out_word.fetch_addr  !== want.fetch_addr  ||
              out_word.write_en    !== want.write_en    ||
              out_word.write_addr  !== want.write_addr  ||
              out_word.pixel_out   !== want.pixel_out   ||
              out_word.done_res    !== want.done_res    ||
              out_word.rejected    !== want.rejected) begin
            note_bad($sformatf("word %0d expected %s got %s", res_cnt, res_text(want),
                               res_text(out_word)));
          end
        end
        res_cnt++;
      end
      if (out_gap > 0) begin
        out_gap--;
        out_stall <= 1'b1;
      end else if (idle_rate > 0 && $urandom_range(1, idle_rate) == 1) begin
        out_gap = $urandom_range(0, 15);
        out_stall <= 1'b1;
      end else begin
        out_stall <= (hold_left > 0);
      end
    end
  end

  task automatic settle();
    do @(negedge clk_i);
    while (send_q.size() != 0 || in_valid || blit_res_q.size() != 0);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic reg_write(reg_idx_e idx, logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PaddrW'(4 * idx);
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i);
    while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegSrcWidth:  src_w_r    = dim_clamp(val);
      RegSrcHeight: src_h_r    = dim_clamp(val);
      RegDstWidth:  dst_w_r    = dim_clamp(val);
      RegDstHeight: dst_h_r    = dim_clamp(val);
      RegKeyColor:  key_r      = val[23:0];
      RegSrcBase:   src_base_r = val;
      RegDstBase:   dst_base_r = val;
      default: ;
    endcase
  endtask

  task automatic program_surfaces(int sw, int sh, int dw, int dh, logic [23:0] key,
                                  logic [31:0] sb, logic [31:0] db);
    settle();
    reg_write(RegSrcWidth, 32'(sw));
    reg_write(RegSrcHeight, 32'(sh));
    reg_write(RegDstWidth, 32'(dw));
    reg_write(RegDstHeight, 32'(dh));
    reg_write(RegKeyColor, 32'(key));
    reg_write(RegSrcBase, sb);
    reg_write(RegDstBase, db);
  endtask

  task automatic fill_random(int n, int rate);
    in_word_t s;
    clip_t c;
    int sent, area, npx;
    bit open;
    sent = 0;
    open = 1'b0;
    @(negedge clk_i);
    idle_rate = rate;
    while (sent < n) begin
      s = start_word();
      c = clip_rect(s);
      area = (c.rej || c.w <= 0 || c.h <= 0) ? 0 : c.w * c.h;
      npx = area;
      if (area > 48 || $urandom_range(0, 7) == 0)
        npx = $urandom_range(0, (area > 48) ? 48 : area);
      send_q.push_back(s);
      repeat (npx) send_q.push_back(pixel_word());
      sent += 1 + npx;
      open = (npx < area);
      if (!open && $urandom_range(0, 7) == 0) send_q.push_back(pixel_word());
    end
    // close an unfinished walk with a rejected start
    if (open) send_q.push_back(mk_start(1, 1, 0, 0, 1, 1, 2047, 0));
  endtask

  task automatic directed_words();
    @(negedge clk_i);
    idle_rate = 4;
    send_q.push_back(mk_pixel(24'h00ff00));
    send_q.push_back(mk_start(0, 0, 0, 0, 0, 0, 0, 0));
    send_q.push_back(mk_pixel(24'h000000));
    send_q.push_back(mk_pixel(24'hffffff));
    send_q.push_back(mk_start(1, 1, 1, 1, 3, 2, 2, 1));
    send_q.push_back(mk_pixel(24'h123456));
    send_q.push_back(mk_pixel(24'hffffff));
    send_q.push_back(mk_pixel(24'h000000));
    send_q.push_back(mk_pixel(24'h654321));
    send_q.push_back(mk_pixel(24'h123456));
    send_q.push_back(mk_pixel(24'habcdef));
    send_q.push_back(mk_start(1, 1, 0, 0, 3, 2, 11, 0));
    send_q.push_back(mk_start(1, 1, 0, 0, 3, 2, -4, 0));
    send_q.push_back(mk_start(1, 1, 0, 0, 3, 2, 0, 6));
    send_q.push_back(mk_start(1, 1, 0, 0, 3, 2, 0, -3));
    send_q.push_back(mk_start(1, 0, 0, 0, 0, 2, 0, 0));
    send_q.push_back(mk_start(1, 1, 8, 0, 2, 2, 0, 0));
    send_q.push_back(mk_start(1, 1, 2, 2, 3, 2, -1, -1));
    send_q.push_back(mk_pixel(24'h0a0b0c));
    send_q.push_back(mk_pixel(24'h123456));
    send_q.push_back(mk_start(1, 1, -2, 0, 3, 1, 0, 0));
    send_q.push_back(mk_pixel(24'h800001));
    send_q.push_back(mk_start(1, 1, -2048, -2048, 2047, 2047, -2048, -2048));
    send_q.push_back(mk_start(1, 1, 2047, 2047, -2048, -2048, 2047, 2047));
    send_q.push_back(mk_start(1, 0, -2048, -2048, 2047, 2047, 0, 0));
    send_q.push_back(mk_start(1, 0, 2047, 2047, 2047, 2047, 0, 0));
  endtask

  initial begin
    int n;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    fill_random(20, 4);
    program_surfaces(8, 6, 10, 5, 24'h123456, 32'h0000_1000, 32'h0000_8000);
    directed_words();
    program_surfaces(2047, 2047, 2047, 2047, 24'hffffff, 32'hffff_fff0, 32'hffff_ffff);
    fill_random(80, 6);
    program_surfaces(0, 0, 0, 0, 24'h000000, 32'h0000_0000, 32'h0000_0000);
    fill_random(20, 3);
    program_surfaces(1, 1, 1, 1, 24'h000000, 32'h8000_0000, 32'h7fff_fffd);
    fill_random(30, 5);
    for (n = 0; n < 4; n++) begin
      program_surfaces(pick_dim(), pick_dim(), pick_dim(), pick_dim(), 24'($urandom),
                       $urandom, $urandom);
      fill_random(110, pick_rate());
    end
    program_surfaces(pick_dim(), pick_dim(), pick_dim(), pick_dim(), 24'($urandom),
                     $urandom, $urandom);
    fill_random(100, 0);
    settle();
    @(negedge clk_i);
    if (bad_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("status: fail");
    $finish;
  end

endmodule
